// ===== hdl/jse_pkg.sv =====
// Shared types, character codes and escape-building function for the JSON string escaper.
package jse_pkg;

    // Output bytes allowed per string, upper bound applied on top of the capacity register
    localparam int MAX_OUT_LEN = 4095;

    localparam int CAP_W   = 12;   // capacity register and running count width
    localparam int SEQ_MAX = 6;    // longest escape sequence
    localparam int LEN_W   = 3;    // width of an escape length (1..6)

    typedef logic [7:0] t_byte;

    // One input's worth of output bytes, first byte in entry 0
    typedef struct packed {
        logic [SEQ_MAX-1:0][7:0] seq;
        logic [LEN_W-1:0]        len;
    } t_burst;

    // Character codes
    localparam t_byte CH_NUL       = 8'h00;
    localparam t_byte CH_BS        = 8'h08;
    localparam t_byte CH_TAB       = 8'h09;
    localparam t_byte CH_LF        = 8'h0A;
    localparam t_byte CH_FF        = 8'h0C;
    localparam t_byte CH_CR        = 8'h0D;
    localparam t_byte CH_CTRL_END  = 8'h20;
    localparam t_byte CH_QUOTE     = 8'h22;
    localparam t_byte CH_ZERO      = 8'h30;
    localparam t_byte CH_BACKSLASH = 8'h5C;
    localparam t_byte CH_LOWER_B   = 8'h62;
    localparam t_byte CH_LOWER_F   = 8'h66;
    localparam t_byte CH_LOWER_N   = 8'h6E;
    localparam t_byte CH_LOWER_R   = 8'h72;
    localparam t_byte CH_LOWER_T   = 8'h74;
    localparam t_byte CH_LOWER_U   = 8'h75;
    localparam t_byte HEX_ALPHA_OFS = 8'h57;  // 'a' - 10

    localparam logic [LEN_W-1:0] LEN_PLAIN   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_SHORT   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_UNICODE = 3'd6;

    // Lowercase hex digit for a nibble
    function automatic t_byte hex_digit(input logic [3:0] nib);
        t_byte res;
        if (nib < 4'd10) begin
            res = CH_ZERO + {4'b0, nib};
        end else begin
            res = HEX_ALPHA_OFS + {4'b0, nib};
        end
        return res;
    endfunction

    // Escape sequence for one source byte
    function automatic t_burst build_escape(input t_byte c);
        t_burst b;
        b.seq    = '0;
        b.len    = LEN_SHORT;
        b.seq[0] = CH_BACKSLASH;
        case (c)
            CH_QUOTE:     b.seq[1] = CH_QUOTE;
            CH_BACKSLASH: b.seq[1] = CH_BACKSLASH;
            CH_LF:        b.seq[1] = CH_LOWER_N;
            CH_CR:        b.seq[1] = CH_LOWER_R;
            CH_TAB:       b.seq[1] = CH_LOWER_T;
            CH_BS:        b.seq[1] = CH_LOWER_B;
            CH_FF:        b.seq[1] = CH_LOWER_F;
            default: begin
                if (c < CH_CTRL_END) begin
                    b.len    = LEN_UNICODE;
                    b.seq[1] = CH_LOWER_U;
                    b.seq[2] = CH_ZERO;
                    b.seq[3] = CH_ZERO;
                    b.seq[4] = hex_digit(c[7:4]);
                    b.seq[5] = hex_digit(c[3:0]);
                end else begin
                    b.len    = LEN_PLAIN;
                    b.seq[0] = c;
                end
            end
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/json_string_escaper.sv =====
// JSON string escaper top level: configuration register, encoder and output serializer.
// Takes one string byte per item (0 ends the string) and emits its JSON-escaped form one
// byte per output item, tlast set on the last byte produced by each input item. An item
// yields one output byte for a plain byte or the terminator, two for a short escape, six
// for a \u00XX escape and none once the string is cut off. The output serializer sends
// these bytes one at a time; a one-entry burst register in front of it lets the next item
// be taken while the current one drains. Once the escape of a byte would push the string
// past min(capacity, MAX_OUT_LEN) bytes, output stops until the end byte; the terminator
// is always emitted. Capacity resets to 159 and should be written only while the block is
// idle.
module json_string_escaper
    import jse_pkg::*;
#(
    parameter int P_MAX_OUT_LEN = MAX_OUT_LEN
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // capacity write channel
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data,
    // input stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] in_byte
    // output stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast    // last_of_run
);

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 12'd159;

    logic [CAP_W-1:0] r_capacity;
    logic             burst_valid;
    logic             burst_ready;
    t_burst           burst;

    // Capacity register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    jse_encoder #(
        .P_MAX_OUT_LEN (P_MAX_OUT_LEN)
    ) u_encoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .i_capacity    (r_capacity),
        .o_burst_valid (burst_valid),
        .i_burst_ready (burst_ready),
        .o_burst       (burst)
    );

    jse_serializer u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_burst_valid (burst_valid),
        .o_burst_ready (burst_ready),
        .i_burst       (burst),
        .o_tvalid      (m_axis_tvalid),
        .i_tready      (m_axis_tready),
        .o_tdata       (m_axis_tdata),
        .o_tlast       (m_axis_tlast)
    );

endmodule

// ===== hdl/jse_encoder.sv =====
// Escape encoder: per-item escape build, space check and string state, into a burst register.
module jse_encoder
    import jse_pkg::*;
#(
    parameter int P_MAX_OUT_LEN = MAX_OUT_LEN
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_byte            i_byte,
    input  logic [CAP_W-1:0] i_capacity,
    output logic             o_burst_valid,
    input  logic             i_burst_ready,
    output t_burst           o_burst
);

    logic [CAP_W-1:0] r_count, n_count;
    logic             r_stopped, n_stopped;
    logic             r_burst_valid, n_burst_valid;
    t_burst           r_burst, n_burst;

    t_burst           esc;
    logic [CAP_W-1:0] limit;
    logic [CAP_W:0]   sum;
    logic             accept;
    logic             emit;

    // Burst register frees up as the serializer takes it
    assign o_ready = !r_burst_valid || i_burst_ready;
    assign accept  = i_valid && o_ready;

    // Effective limit and space check
    always_comb begin
        esc = build_escape(i_byte);
        if ({{(17-CAP_W){1'b0}}, i_capacity} > 17'(P_MAX_OUT_LEN)) begin
            limit = CAP_W'(P_MAX_OUT_LEN);
        end else begin
            limit = i_capacity;
        end
        sum = {1'b0, r_count} + (CAP_W+1)'(esc.len);
    end

    // String state and burst selection
    always_comb begin
        n_count   = r_count;
        n_stopped = r_stopped;
        n_burst   = r_burst;
        emit      = 1'b0;
        if (accept) begin
            if (i_byte == CH_NUL) begin
                // terminator always goes out and restarts the string
                emit        = 1'b1;
                n_burst.seq = '0;
                n_burst.len = LEN_PLAIN;
                n_count     = '0;
                n_stopped   = 1'b0;
            end else if (!r_stopped) begin
                if (sum > {1'b0, limit}) begin
                    n_stopped = 1'b1;
                end else begin
                    emit    = 1'b1;
                    n_burst = esc;
                    n_count = sum[CAP_W-1:0];
                end
            end
        end
        if (emit) begin
            n_burst_valid = 1'b1;
        end else if (i_burst_ready) begin
            n_burst_valid = 1'b0;
        end else begin
            n_burst_valid = r_burst_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_stopped     <= 1'b0;
            r_burst_valid <= 1'b0;
        end else begin
            r_count       <= n_count;
            r_stopped     <= n_stopped;
            r_burst_valid <= n_burst_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        r_burst <= n_burst;
    end

    assign o_burst_valid = r_burst_valid;
    assign o_burst       = r_burst;

endmodule

// ===== hdl/jse_serializer.sv =====
// Output serializer: sends a burst one byte per cycle while the receiver is ready, tlast on its final byte.
module jse_serializer
    import jse_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_burst_valid,
    output logic   o_burst_ready,
    input  t_burst i_burst,
    output logic   o_tvalid,
    input  logic   i_tready,
    output t_byte  o_tdata,
    output logic   o_tlast
);

    logic             r_valid;
    logic [LEN_W-1:0] r_idx;
    t_burst           r_burst;

    logic last;
    logic done;

    assign last          = (r_idx == r_burst.len - LEN_W'(1));
    assign done          = r_valid && i_tready && last;
    assign o_burst_ready = !r_valid || done;

    // Byte pointer and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_burst_valid && o_burst_ready) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (done) begin
            r_valid <= 1'b0;
        end else if (r_valid && i_tready) begin
            r_idx <= r_idx + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_burst_valid && o_burst_ready) begin
            r_burst <= i_burst;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_burst.seq[r_idx];
    assign o_tlast  = last;

endmodule

// ===== sim/json_string_escaper_checker.sv =====
// Checker for the JSON string escaper: watches all channels, predicts output bytes and compares.
`timescale 1ns / 100ps

module json_string_escaper_checker
    import jse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [7:0]       i_in_byte,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [7:0]       i_out_byte,
    input  logic             i_out_last,
    output int               o_fail_count,
    output int               o_pending
);

    localparam logic [CAP_W-1:0] CAP_RESET   = 12'd159;
    localparam int               REPORT_MAX  = 10;
    localparam logic [0:15][7:0] HEX_CHARS   = "0123456789abcdef";

    // one expected output item: escaped byte plus end-of-run flag
    typedef struct packed {
        t_byte data;
        logic  last;
    } t_esc_item;

    t_esc_item        esc_expected_q[$];
    t_esc_item        head_item;
    logic [CAP_W-1:0] capacity_r;
    logic [CAP_W-1:0] written_r;
    logic             cut_off_r;
    int               mismatch_cnt = 0;

    // Escape one source byte and queue the bytes it should produce
    task automatic predict_escape(input t_byte c);
        t_byte seq [SEQ_MAX];
        int    n;
        int    lim;
        if (c == CH_NUL) begin
            esc_expected_q.push_back('{data: CH_NUL, last: 1'b1});
            written_r = '0;
            cut_off_r = 1'b0;
            return;
        end
        if (cut_off_r) return;

        lim = int'(capacity_r);
        if (lim > MAX_OUT_LEN) lim = MAX_OUT_LEN;

        seq[0] = CH_BACKSLASH;
        n      = 2;
        case (c)
            CH_QUOTE:     seq[1] = CH_QUOTE;
            CH_BACKSLASH: seq[1] = CH_BACKSLASH;
            CH_LF:        seq[1] = CH_LOWER_N;
            CH_CR:        seq[1] = CH_LOWER_R;
            CH_TAB:       seq[1] = CH_LOWER_T;
            CH_BS:        seq[1] = CH_LOWER_B;
            CH_FF:        seq[1] = CH_LOWER_F;
            default: begin
                if (c < CH_CTRL_END) begin
                    // other control bytes: \u00XX, lowercase hex
                    seq[1] = CH_LOWER_U;
                    seq[2] = CH_ZERO;
                    seq[3] = CH_ZERO;
                    seq[4] = HEX_CHARS[c[7:4]];
                    seq[5] = HEX_CHARS[c[3:0]];
                    n      = 6;
                end else begin
                    seq[0] = c;
                    n      = 1;
                end
            end
        endcase

        // whole escape must fit, otherwise the string is cut off here
        if (int'(written_r) + n > lim) begin
            cut_off_r = 1'b1;
            return;
        end
        for (int k = 0; k < n; k++) begin
            esc_expected_q.push_back('{data: seq[k], last: (k == n - 1)});
        end
        written_r = written_r + CAP_W'(n);
    endtask

    // Track config, predict on accepted input items, compare on accepted output items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity_r = CAP_RESET;
            written_r  = '0;
            cut_off_r  = 1'b0;
            esc_expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) capacity_r = i_cfg_data;
            if (i_in_valid && i_in_ready) predict_escape(i_in_byte);
            if (i_out_valid && i_out_ready) begin
                if (esc_expected_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("%0t: unexpected output item byte %02h last %0b",
                                 $time, i_out_byte, i_out_last);
                end else begin
                    head_item = esc_expected_q.pop_front();
                    if (head_item.data != i_out_byte || head_item.last != i_out_last) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                            $display("%0t: expected byte %02h last %0b, got %02h last %0b",
                                     $time, head_item.data, head_item.last,
                                     i_out_byte, i_out_last);
                    end
                end
            end
        end
        o_pending    <= esc_expected_q.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

// ===== sim/json_string_escaper_tb.sv =====
// Testbench top for the JSON string escaper: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module json_string_escaper_tb;
    import jse_pkg::*;

    localparam int RST_CYCLES  = 12;
    localparam int CFG_SETTLE  = 8;
    localparam int END_CYCLES  = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 43;
    localparam int NUM_PHASES  = 8;

    typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    logic [7:0]       in_byte;
    logic             out_valid;
    logic             out_ready;
    logic [7:0]       out_byte;
    logic             out_last;

    int fail_count;
    int pending;
    int items_sent = 0;
    int burst_left = 0;
    int stall_cnt  = 0;
    bit in_held    = 1'b0;
    bit hold_req   = 1'b0;

    json_string_escaper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_byte),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_byte),
        .m_axis_tlast  (out_last)
    );

    json_string_escaper_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_byte    (in_byte),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_byte   (out_byte),
        .i_out_last   (out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one source byte; often idle between bursts of random length
    task automatic send_byte(input t_byte b);
        int gap;
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge i_clk); while (!in_ready);
        items_sent++;
        in_held = 1'b1;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                in_held = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Stop offering and wait until every expected output item has come
    task automatic wait_drain;
        if (in_held) begin
            in_valid <= 1'b0;
            in_held = 1'b0;
        end
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_drain();
        repeat (CFG_SETTLE) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Non-zero string byte, weighted toward escapes and the high half
    function automatic t_byte random_text_byte();
        t_byte b;
        case ($urandom_range(0, 9))
            0, 1: b = t_byte'($urandom_range(1, 31));
            2:    b = ($urandom_range(0, 1) == 1) ? CH_QUOTE : CH_BACKSLASH;
            3: begin
                case ($urandom_range(0, 4))
                    0:       b = CH_LF;
                    1:       b = CH_CR;
                    2:       b = CH_TAB;
                    3:       b = CH_BS;
                    default: b = CH_FF;
                endcase
            end
            4, 5: b = t_byte'($urandom_range(127, 255));
            default: b = t_byte'($urandom_range(32, 126));
        endcase
        return b;
    endfunction

    task automatic send_random_string;
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++) send_byte(random_text_byte());
        send_byte(CH_NUL);
    endtask

    // Receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        int       cyc;
        rx_mode   = RX_STREAM;
        mode_left = 0;
        cyc       = 0;
        out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                cyc++;
                case (rx_mode)
                    RX_STREAM: out_ready <= 1'b1;
                    RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= (cyc % 3 != 0);
                endcase
            end
        end
    end

    // Watchdog on cycles with no accepted item on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // Main stimulus
    initial begin
        logic [CAP_W-1:0] cap;
        i_rst_n   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_byte   = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset capacity: every escape class in one string
        send_byte(8'h41);
        send_byte(CH_QUOTE);
        send_byte(CH_BACKSLASH);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_TAB);
        send_byte(CH_BS);
        send_byte(CH_FF);
        send_byte(8'h01);
        send_byte(8'h1F);
        send_byte(8'h0B);
        send_byte(CH_CTRL_END);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(CH_NUL);

        // zero capacity: only the terminator comes out
        write_capacity('0);
        send_byte(8'h41);
        send_byte(CH_NUL);

        // escape that does not fit stops the string; later bytes are dropped
        write_capacity(12'd7);
        send_byte(8'h41);
        send_byte(8'h41);
        send_byte(8'h01);
        send_byte(8'h41);
        send_byte(CH_NUL);

        // random strings under a range of capacities
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       cap = 12'd4095;
                1:       cap = 12'd1;
                2:       cap = CAP_W'($urandom_range(2, 12));
                3:       cap = 12'd6;
                4:       cap = CAP_W'($urandom_range(13, 60));
                5:       cap = '0;
                6:       cap = CAP_W'($urandom_range(61, 300));
                default: cap = 12'd159;
            endcase
            write_capacity(cap);
            // long output hold-off while input keeps coming
            if (p == 0) hold_req = 1'b1;
            while (items_sent < (p + 1) * PHASE_ITEMS + 23)
                send_random_string();
        end

        wait_drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
